// ===== rtl/tlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared constants, operation codes and port structs for the two-level
// page table manager.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpm_pkg;

    // table geometry
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int DI_W          = $clog2(DIR_ENTRIES);
    localparam int TI_W          = $clog2(TABLE_ENTRIES);
    localparam int TA_W          = DI_W + TI_W;
    localparam int TBL_DEPTH     = DIR_ENTRIES << TI_W;

    // field widths
    localparam int ENTRY_W = 32;
    localparam int FRAME_W = 20;
    localparam int FLAG_W  = 12;
    localparam int VIDX_W  = 10;
    localparam int COUNT_W = 21;

    // operation codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_MAP       = 2'd1;
    localparam logic [1:0] OP_UNMAP     = 2'd2;

    // entry flag bits
    localparam logic [FLAG_W-1:0] FLAG_PRESENT = 12'h001;
    localparam logic [FLAG_W-1:0] DIR_DEFAULT  = 12'h003;

    // directory memory port
    typedef struct packed {
        logic               we;
        logic [DI_W-1:0]    wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic [DI_W-1:0]    rd_addr;
    } dir_port_t;

    // page table memory port
    typedef struct packed {
        logic               we;
        logic [TA_W-1:0]    wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic [TA_W-1:0]    rd_addr;
    } tbl_port_t;

    // result handed to the output stage
    typedef struct packed {
        logic               valid;
        logic               status;
        logic [ENTRY_W-1:0] phys;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/tlpm_ram.sv =====
// ----------------------------------------------------------------------------
// tlpm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/tlpm_walker.sv =====
// ----------------------------------------------------------------------------
// tlpm_walker
// Sequencer that clears the tables after reset and walks directory and
// table entries one page at a time for translate, map and unmap.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_walker
    import tlpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [31:0]          virt_addr,
    input  wire logic [31:0]          phys_addr,
    input  wire logic [FLAG_W-1:0]    page_flags,
    input  wire logic [COUNT_W-1:0]   page_count,
    input  wire logic                 cfg_we,
    input  wire logic [FRAME_W-1:0]   cfg_frame,
    output dir_port_t                 dir_port,
    input  wire logic [ENTRY_W-1:0]   dir_rd_data,
    output tbl_port_t                 tbl_port,
    input  wire logic [ENTRY_W-1:0]   tbl_rd_data,
    output res_t                      res,
    input  wire logic                 res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [FRAME_W-1:0]   vpage_reg, vpage_next;
    logic [FRAME_W-1:0]   ppage_reg, ppage_next;
    logic [FLAG_W-1:0]    off_reg, off_next;
    logic [FLAG_W-1:0]    flags_reg, flags_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [TA_W-1:0]      clr_reg, clr_next;
    logic                 status_reg, status_next;
    logic [ENTRY_W-1:0]   phys_reg, phys_next;

    logic [VIDX_W-1:0]    di;
    logic [VIDX_W-1:0]    ti;
    logic                 idx_ok;
    logic                 dir_p;
    logic                 pte_p;
    logic                 last_page;

    // index split of the current page
    assign di        = vpage_reg[FRAME_W-1:VIDX_W];
    assign ti        = vpage_reg[VIDX_W-1:0];
    assign idx_ok    = ({1'b0, di} < (VIDX_W+1)'(DIR_ENTRIES))
                    && ({1'b0, ti} < (VIDX_W+1)'(TABLE_ENTRIES));
    assign dir_p     = dir_rd_data[0];
    assign pte_p     = tbl_rd_data[0];
    assign last_page = (cnt_reg == COUNT_W'(1));

    // next state and memory requests
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        vpage_next  = vpage_reg;
        ppage_next  = ppage_reg;
        off_next    = off_reg;
        flags_next  = flags_reg;
        cnt_next    = cnt_reg;
        frame_next  = frame_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        phys_next   = phys_reg;

        in_ready         = 1'b0;
        dir_port         = '0;
        dir_port.rd_addr = di[DI_W-1:0];
        tbl_port         = '0;
        tbl_port.rd_addr = {di[DI_W-1:0], ti[TI_W-1:0]};
        res.valid        = 1'b0;
        res.status       = status_reg;
        res.phys         = phys_reg;

        case (state_reg)
            // zero both memories, one table entry per cycle
            S_CLEAR:
            begin
                tbl_port.we      = 1'b1;
                tbl_port.wr_addr = clr_reg;
                tbl_port.wr_data = '0;
                if (clr_reg < TA_W'(DIR_ENTRIES))
                begin
                    dir_port.we      = 1'b1;
                    dir_port.wr_addr = clr_reg[DI_W-1:0];
                    dir_port.wr_data = '0;
                end
                clr_next = clr_reg + TA_W'(1);
                if (clr_reg == TA_W'(TBL_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take a new transaction
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = opcode;
                    vpage_next  = virt_addr[31:12];
                    off_next    = virt_addr[11:0];
                    ppage_next  = phys_addr[31:12];
                    flags_next  = page_flags | FLAG_PRESENT;
                    status_next = 1'b0;
                    phys_next   = '0;
                    if (opcode == OP_TRANSLATE)
                    begin
                        cnt_next   = COUNT_W'(1);
                        state_next = S_READ;
                    end
                    else if ((opcode == OP_MAP || opcode == OP_UNMAP)
                             && page_count != '0)
                    begin
                        cnt_next   = page_count;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            // issue directory and table reads for the current page
            S_READ:
            begin
                if (!idx_ok)
                begin
                    status_next = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end

            // check entries and write back
            S_EVAL:
            begin
                case (op_reg)
                    OP_TRANSLATE:
                    begin
                        if (dir_p && pte_p)
                        begin
                            phys_next = {tbl_rd_data[31:12], off_reg};
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    OP_MAP:
                    begin
                        // allocate a page table for an absent directory slot
                        if (!dir_p)
                        begin
                            dir_port.we      = 1'b1;
                            dir_port.wr_addr = di[DI_W-1:0];
                            dir_port.wr_data = {frame_reg, flags_reg | DIR_DEFAULT};
                            frame_next       = frame_reg + FRAME_W'(1);
                        end
                        if (pte_p)
                        begin
                            status_next = 1'b1;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            tbl_port.we      = 1'b1;
                            tbl_port.wr_addr = tbl_port.rd_addr;
                            tbl_port.wr_data = {ppage_reg, flags_reg};
                            vpage_next       = vpage_reg + FRAME_W'(1);
                            ppage_next       = ppage_reg + FRAME_W'(1);
                            cnt_next         = cnt_reg - COUNT_W'(1);
                            state_next       = last_page ? S_RESP : S_READ;
                        end
                    end
                    OP_UNMAP:
                    begin
                        if (!dir_p || !pte_p)
                        begin
                            status_next = 1'b1;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            tbl_port.we      = 1'b1;
                            tbl_port.wr_addr = tbl_port.rd_addr;
                            tbl_port.wr_data = '0;
                            vpage_next       = vpage_reg + FRAME_W'(1);
                            cnt_next         = cnt_reg - COUNT_W'(1);
                            state_next       = last_page ? S_RESP : S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // hand the result to the output stage
            S_RESP:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pool base write reloads the frame counter
        if (cfg_we)
        begin
            frame_next = cfg_frame;
        end
    end

    // state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            op_reg     <= OP_TRANSLATE;
            vpage_reg  <= '0;
            ppage_reg  <= '0;
            off_reg    <= '0;
            flags_reg  <= '0;
            cnt_reg    <= '0;
            frame_reg  <= '0;
            clr_reg    <= '0;
            status_reg <= 1'b0;
            phys_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            vpage_reg  <= vpage_next;
            ppage_reg  <= ppage_next;
            off_reg    <= off_next;
            flags_reg  <= flags_next;
            cnt_reg    <= cnt_next;
            frame_reg  <= frame_next;
            clr_reg    <= clr_next;
            status_reg <= status_next;
            phys_reg   <= phys_next;
        end
    end

`ifndef SYNTHESIS
    // a present table entry is only written under a present or new directory entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && tbl_port.we && tbl_port.wr_data[0])
        |-> (dir_rd_data[0] || dir_port.we))
        else $error("page entry written under absent directory entry");

    // frame counter moves only on allocation or a pool base write
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(state_reg == S_EVAL && dir_port.we) && !cfg_we) |=> $stable(frame_reg))
        else $error("frame counter moved without allocation");

    // only a successful translate returns a nonzero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (op_reg != OP_TRANSLATE || res.status)) |-> (res.phys == '0))
        else $error("nonzero address on failed or non-translate transaction");

    // each evaluated page moves to the next page or to the response
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |=> (state_reg == S_READ || state_reg == S_RESP))
        else $error("bad step after page evaluation");
`endif

endmodule

`default_nettype wire

// ===== rtl/two_level_page_table_manager_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_manager_core
// Two-level page table: translate, map and unmap over a page directory and
// the page tables beneath it.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) takes one transaction: opcode,
//   virt_addr, phys_addr, page_flags, page_count. Output channel
//   (out_valid/out_ready) returns one status and phys_result per transaction.
//   Config channel (cfg_valid/cfg_ready) writes table_pool_base_frame and
//   reloads the table frame counter; write it only while the block is idle.
// Sequencing
//   One transaction is in flight at a time. Each page is handled in a read
//   step, which reads the directory and table memories together, and an
//   evaluate step, which checks the entries and writes back. Map or unmap
//   stops early at a failing page, and a zero page count or unknown opcode
//   goes straight to the response. The next transaction is taken from the
//   idle step, which the sequencer enters as its result moves into the
//   output register.
// Reset
//   After reset a clearing pass zeroes both memories, one table entry per
//   cycle; in_ready stays low meanwhile, config writes are taken.
// Backpressure
//   While out_ready is low a held result blocks the next one from leaving
//   the sequencer; the sequencer waits in its response step.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_manager_core
    import tlpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [31:0]          virt_addr,
    input  wire logic [31:0]          phys_addr,
    input  wire logic [FLAG_W-1:0]    page_flags,
    input  wire logic [COUNT_W-1:0]   page_count,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      status,
    output logic [31:0]               phys_result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [FRAME_W-1:0]   table_pool_base_frame
);

    dir_port_t            dir_port;
    tbl_port_t            tbl_port;
    logic [ENTRY_W-1:0]   dir_rd_data;
    logic [ENTRY_W-1:0]   tbl_rd_data;
    res_t                 res;
    logic                 res_ready;
    logic                 cfg_we;

    logic                 out_valid_reg;
    logic                 status_reg;
    logic [ENTRY_W-1:0]   phys_result_reg;

    // config transaction
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer
    tlpm_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .virt_addr   (virt_addr),
        .phys_addr   (phys_addr),
        .page_flags  (page_flags),
        .page_count  (page_count),
        .cfg_we      (cfg_we),
        .cfg_frame   (table_pool_base_frame),
        .dir_port    (dir_port),
        .dir_rd_data (dir_rd_data),
        .tbl_port    (tbl_port),
        .tbl_rd_data (tbl_rd_data),
        .res         (res),
        .res_ready   (res_ready)
    );

    // page directory
    tlpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk     (clk),
        .we      (dir_port.we),
        .wr_addr (dir_port.wr_addr),
        .wr_data (dir_port.wr_data),
        .rd_addr (dir_port.rd_addr),
        .rd_data (dir_rd_data)
    );

    // page tables, one row per directory slot
    tlpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk     (clk),
        .we      (tbl_port.we),
        .wr_addr (tbl_port.wr_addr),
        .wr_data (tbl_port.wr_data),
        .rd_addr (tbl_port.rd_addr),
        .rd_data (tbl_rd_data)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            status_reg      <= 1'b0;
            phys_result_reg <= '0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg   <= 1'b1;
            status_reg      <= res.status;
            phys_result_reg <= res.phys;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign phys_result = phys_result_reg;

endmodule

`default_nettype wire

// ===== dv/two_level_page_table_manager_core_tb.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_manager_core_tb
// Self-checking bench for the page table manager. A shadow copy of the page
// directory, the page tables and the table frame counter predicts status and
// translated address for every accepted request. Directed cases cover empty
// lookups, partial map and unmap, address and frame counter wrap. Random
// traffic then runs mostly inside a small set of hot directory slots, with
// source bursts and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_manager_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpm_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam bit [31:0]  PAGE_BYTES = 32'h1000;
    localparam int unsigned MAX_PAGES = 1048576;

    typedef struct {
        bit        status;
        bit [31:0] phys;
    } reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           opcode;
    logic [31:0]          virt_addr;
    logic [31:0]          phys_addr;
    logic [FLAG_W-1:0]    page_flags;
    logic [COUNT_W-1:0]   page_count;
    logic                 out_valid;
    logic                 out_ready;
    logic                 status;
    logic [31:0]          phys_result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FRAME_W-1:0]   pool_frame_wr;

    // shadow page table state
    bit [31:0]          shadow_dir [DIR_ENTRIES];
    bit [31:0]          shadow_leaf [bit [19:0]];
    bit [FRAME_W-1:0]   shadow_frame_ctr;

    // replies still owed by the block
    reply_t             owed_replies [$];
    int unsigned        fault_count;

    // source and sink pacing
    bit                 src_gaps;
    int unsigned        burst_left;
    bit                 sink_stalls;
    int unsigned        sink_run;
    bit                 sink_level;

    two_level_page_table_manager_core u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .opcode                (opcode),
        .virt_addr             (virt_addr),
        .phys_addr             (phys_addr),
        .page_flags            (page_flags),
        .page_count            (page_count),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .status                (status),
        .phys_result           (phys_result),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .table_pool_base_frame (pool_frame_wr)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // leaf entry seen by a walk, zero when either level is absent
    function automatic bit [31:0] leaf_of(input bit [31:0] va);
        if (va[31:22] >= DIR_ENTRIES || va[21:12] >= TABLE_ENTRIES)
            return 32'h0;
        if (!shadow_dir[va[31:22]][0])
            return 32'h0;
        if (!shadow_leaf.exists(va[31:12]))
            return 32'h0;
        return shadow_leaf[va[31:12]];
    endfunction

    // apply one request to the shadow tables and work out its reply
    task automatic walk_tables(input logic [1:0] op, input bit [31:0] va,
                               input bit [31:0] pa, input bit [FLAG_W-1:0] flags,
                               input bit [COUNT_W-1:0] count, output reply_t rep);
        bit [31:0]    v;
        bit [31:0]    p;
        bit [31:0]    ent;
        bit [11:0]    f;
        bit [9:0]     di;
        int unsigned  n;
        int           t;
        rep.status = 1'b0;
        rep.phys   = 32'h0;
        v = {va[31:12], 12'h0};
        p = {pa[31:12], 12'h0};
        f = flags | FLAG_PRESENT;
        case (op)
            OP_TRANSLATE:
            begin
                ent = leaf_of(va);
                if (ent[0])
                    rep.phys = {ent[31:12], va[11:0]};
                else
                    rep.status = 1'b1;
            end
            OP_MAP:
            begin
                for (n = 0; n < count; n++)
                begin
                    di = v[31:22];
                    if (v[31:22] >= DIR_ENTRIES || v[21:12] >= TABLE_ENTRIES)
                    begin
                        rep.status = 1'b1;
                        break;
                    end
                    // allocate a fresh table for an absent slot
                    if (!shadow_dir[di][0])
                    begin
                        shadow_dir[di] = {shadow_frame_ctr, f | DIR_DEFAULT};
                        shadow_frame_ctr++;
                        for (t = 0; t < TABLE_ENTRIES; t++)
                            shadow_leaf.delete({di, t[9:0]});
                    end
                    ent = leaf_of(v);
                    if (ent[0])
                    begin
                        rep.status = 1'b1;
                        break;
                    end
                    shadow_leaf[v[31:12]] = {p[31:12], f};
                    p += PAGE_BYTES;
                    v += PAGE_BYTES;
                end
            end
            OP_UNMAP:
            begin
                for (n = 0; n < count; n++)
                begin
                    ent = leaf_of(v);
                    if (!ent[0])
                    begin
                        rep.status = 1'b1;
                        break;
                    end
                    shadow_leaf[v[31:12]] = 32'h0;
                    v += PAGE_BYTES;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // send one request; called at a falling edge, returns at a falling edge
    task automatic issue_request(input logic [1:0] op, input bit [31:0] va,
                                 input bit [31:0] pa, input bit [FLAG_W-1:0] flags,
                                 input bit [COUNT_W-1:0] count);
        reply_t rep;
        if (src_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        virt_addr  <= va;
        phys_addr  <= pa;
        page_flags <= flags;
        page_count <= count;
        do
            @(posedge clk);
        while (!in_ready);
        walk_tables(op, va, pa, flags, count, rep);
        owed_replies.push_back(rep);
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    // stop sending and wait for every owed reply
    task automatic drain_pending();
        in_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write the table pool base once every owed reply has come back
    task automatic load_pool_base(input bit [FRAME_W-1:0] frame);
        drain_pending();
        repeat (8) @(negedge clk);
        cfg_valid     <= 1'b1;
        pool_frame_wr <= frame;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_frame_ctr = frame;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // page-aligned address, mostly in a few busy directory slots
    function automatic bit [31:0] hot_page();
        bit [9:0] di;
        bit [9:0] ti;
        case ($urandom_range(0, 6))
            0:       di = 10'd0;
            1:       di = 10'd1;
            2:       di = 10'd2;
            3:       di = 10'd511;
            4:       di = 10'd512;
            5:       di = 10'd1023;
            default: di = 10'($urandom_range(0, 1023));
        endcase
        if ($urandom_range(0, 3) == 0)
            ti = 10'd1000 + 10'($urandom_range(0, 23));
        else
            ti = 10'($urandom_range(0, 31));
        return {di, ti, 12'h0};
    endfunction

    // lookups on empty tables, unknown operation, zero page counts
    task automatic test_empty_lookups();
        issue_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 21'd0);
        issue_request(OP_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 21'h1F_FFFF);
        issue_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 21'h1F_FFFF);
        issue_request(OP_MAP, 32'h0040_0000, 32'h1234_5000, 12'hFFF, 21'd0);
        issue_request(OP_UNMAP, 32'h0040_0000, 32'h0, 12'h000, 21'd0);
    endtask

    // unaligned map, walk inside it, remap of a mapped page with the full count
    task automatic test_map_and_walk();
        issue_request(OP_MAP, 32'h00C0_0ABC, 32'h8000_0FFF, 12'hFFF, 21'd3);
        issue_request(OP_TRANSLATE, 32'h00C0_1123, 32'h0, 12'h000, 21'd0);
        issue_request(OP_MAP, 32'h00C0_2000, 32'h0, 12'h000, COUNT_W'(MAX_PAGES));
        issue_request(OP_TRANSLATE, 32'h00C0_3000, 32'h0, 12'h000, 21'd0);
    endtask

    // map and unmap that stop part way, earlier pages keep their change
    task automatic test_partial_runs();
        issue_request(OP_MAP, 32'h00BF_E000, 32'h0000_1000, 12'h000, 21'd8);
        issue_request(OP_TRANSLATE, 32'h00BF_F010, 32'h0, 12'h000, 21'd0);
        issue_request(OP_UNMAP, 32'h00BF_F000, 32'h0, 12'h000, COUNT_W'(MAX_PAGES));
        issue_request(OP_TRANSLATE, 32'h00C0_1000, 32'h0, 12'h000, 21'd0);
        issue_request(OP_TRANSLATE, 32'h00BF_E000, 32'h0, 12'h000, 21'd0);
    endtask

    // virtual and physical wrap past the top, frame counter wrap
    task automatic test_wraparound();
        load_pool_base(20'hF_FFFF);
        issue_request(OP_MAP, 32'hFFFF_E000, 32'hFFFF_E000, 12'h5A5, 21'd4);
        issue_request(OP_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000, 21'd0);
        issue_request(OP_TRANSLATE, 32'hFFFF_F800, 32'h0, 12'h000, 21'd0);
        issue_request(OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000, 21'd2);
        issue_request(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 21'd0);
    endtask

    // random traffic, mostly in hot slots so walks hit mapped pages
    task automatic test_random_traffic(input int unsigned n_items, input bit gaps,
                                       input bit stalls);
        bit [31:0]    va;
        bit [31:0]    base;
        bit [31:0]    ent;
        bit [COUNT_W-1:0] cnt;
        int unsigned  r;
        int unsigned  k;
        bit           found;
        src_gaps    = gaps;
        sink_stalls = stalls;
        burst_left  = 0;
        repeat (n_items)
        begin
            r    = $urandom_range(0, 99);
            base = hot_page();
            va   = {base[31:12], 12'($urandom_range(0, 4095))};
            if (r < 35)
            begin
                issue_request(OP_TRANSLATE, (r < 4) ? $urandom : va, $urandom,
                              FLAG_W'($urandom), COUNT_W'($urandom));
            end
            else if (r < 60)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? 21'd0 : 21'($urandom_range(1, 8));
                issue_request(OP_MAP, (r < 42) ? $urandom : ((r & 1) ? va : base),
                              $urandom, FLAG_W'($urandom), cnt);
            end
            else if (r < 65)
            begin
                // long map that runs into a mapped page close by, or a short one if none is found
                k     = 0;
                found = 1'b0;
                while (k < 4 && !found)
                begin
                    ent = leaf_of(base + k * PAGE_BYTES);
                    if (ent[0])
                        found = 1'b1;
                    else
                        k++;
                end
                cnt = found ? 21'($urandom_range(k + 1, MAX_PAGES)) :
                              21'($urandom_range(1, 4));
                issue_request(OP_MAP, base, $urandom, FLAG_W'($urandom), cnt);
            end
            else if (r < 85)
            begin
                cnt = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, MAX_PAGES)) :
                                                    21'($urandom_range(1, 8));
                issue_request(OP_UNMAP, va, $urandom, FLAG_W'($urandom), cnt);
            end
            else if (r < 92)
            begin
                issue_request((r & 1) ? OP_UNUSED : OP_TRANSLATE, $urandom, $urandom,
                              FLAG_W'($urandom), COUNT_W'($urandom));
            end
            else
            begin
                issue_request(OP_UNMAP, $urandom, $urandom, FLAG_W'($urandom),
                              21'($urandom_range(0, MAX_PAGES)));
            end
        end
    endtask

    // sink: runs of ready and stall, with an occasional long stall
    always @(negedge clk)
    begin
        if (!sink_stalls)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            if (sink_run == 0)
            begin
                sink_level = !sink_level;
                if (sink_level)
                    sink_run = $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    sink_run = $urandom_range(20, 40);
                else
                    sink_run = $urandom_range(1, 5);
            end
            sink_run--;
            out_ready <= sink_level;
        end
    end

    // compare each reply transaction with the oldest owed reply
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_replies.size() == 0)
            begin
                $error("reply with none owed: status %0d phys_result %08h",
                       status, phys_result);
                fault_count++;
            end
            else
            begin
                want = owed_replies.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    fault_count++;
                end
                if (phys_result !== want.phys)
                begin
                    $error("phys_result mismatch: expected %08h, got %08h",
                           want.phys, phys_result);
                    fault_count++;
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        opcode           = OP_TRANSLATE;
        virt_addr        = 32'h0;
        phys_addr        = 32'h0;
        page_flags       = '0;
        page_count       = '0;
        out_ready        = 1'b1;
        cfg_valid        = 1'b0;
        pool_frame_wr    = '0;
        fault_count      = 0;
        src_gaps         = 1'b0;
        burst_left       = 0;
        sink_stalls      = 1'b0;
        sink_run         = 0;
        sink_level       = 1'b0;
        shadow_frame_ctr = '0;
        foreach (shadow_dir[i])
            shadow_dir[i] = 32'h0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // write taken during the clearing pass after reset
        load_pool_base(20'h0_0000);
        test_empty_lookups();
        test_map_and_walk();
        test_partial_runs();
        test_wraparound();

        load_pool_base(20'($urandom_range(1, 20'hF_FFFE)));
        test_random_traffic(300, 1'b0, 1'b0);
        test_random_traffic(300, 1'b1, 1'b1);
        load_pool_base(20'h0_0000);
        test_random_traffic(300, 1'b1, 1'b1);

        drain_pending();
        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tlpm_pkg.sv
rtl/tlpm_ram.sv
rtl/tlpm_walker.sv
rtl/two_level_page_table_manager_core.sv
dv/two_level_page_table_manager_core_tb.sv
